// ===== rtl/ljpf_pkg.sv =====
// ljpf_pkg: shared widths, constants, codes and types of the pair force accumulator
// no dependencies; used by every file of the block

package ljpf_pkg;

    // default parameter values
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF  = 16;

    // field widths
    localparam int DIAM_W     = 24;
    localparam int BOX_W      = 31;
    localparam int CUT_W      = 20;
    localparam int FORCE_W    = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // internal widths
    localparam int SEP_BITS = 26;
    localparam int MAG_W    = SEP_BITS;
    localparam int COMP_W   = SEP_BITS + 1;
    localparam int DSUM_W   = DIAM_W + 1;
    localparam int DSQ_W    = 2 * DSUM_W;
    localparam int R2_W     = 2 * MAG_W + 2;
    localparam int S_W      = 38;
    localparam int T_W      = 44;
    localparam int U_W      = 50;
    localparam int X_W      = 52;
    localparam int H_W      = U_W - 17;
    localparam int VMAG_W   = X_W + 6;
    localparam int PROD_W   = VMAG_W + MAG_W;
    localparam int Q_W      = 47;
    localparam int THR_SHIFT = 18;
    localparam int S_SHIFT   = 30;

    // shared multiply / divide unit
    localparam int MD_A_W        = 64;
    localparam int MD_P_W        = 128;
    localparam int MD_DIGIT      = 16;
    localparam int MD_MUL_STEPS  = MD_A_W / MD_DIGIT;
    localparam int MD_DIV_STEPS  = MD_P_W;
    localparam int MD_CNT_W      = 8;

    localparam logic [MD_A_W-1:0] S_CAP    = {{(MD_A_W-S_W){1'b0}}, {S_W{1'b1}}};
    localparam logic [MD_A_W-1:0] TERM_CAP = {{(MD_A_W-Q_W){1'b0}}, {Q_W{1'b1}}};
    localparam logic [THR_SHIFT-1:0] THR_ROUND = {THR_SHIFT{1'b1}};

    // queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X  = 2'd0,
        REG_BOX_Y  = 2'd1,
        REG_CUTOFF = 2'd2
    } cfg_reg_e;

    // classified pair, front to back
    typedef struct packed {
        logic signed [COMP_W-1:0] dx;
        logic signed [COMP_W-1:0] dy;
        logic signed [COMP_W-1:0] dz;
        logic [DSUM_W-1:0]        dsum;
        logic                     active;
        logic                     last;
    } pair_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R2,
        ST_DSQ,
        ST_THR,
        ST_S,
        ST_T,
        ST_U,
        ST_X,
        ST_V,
        ST_VM,
        ST_VD,
        ST_EMIT
    } back_state_e;

endpackage

// ===== rtl/ljpf_if.sv =====
// ljpf_if: valid/ready channel interfaces of the pair force accumulator
// depends on ljpf_pkg

interface ljpf_pair_if #(
    parameter int POSITION_WIDTH = ljpf_pkg::POSITION_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [POSITION_WIDTH-1:0]  target_x;
    logic signed [POSITION_WIDTH-1:0]  target_y;
    logic signed [POSITION_WIDTH-1:0]  target_z;
    logic signed [POSITION_WIDTH-1:0]  neighbour_x;
    logic signed [POSITION_WIDTH-1:0]  neighbour_y;
    logic signed [POSITION_WIDTH-1:0]  neighbour_z;
    logic [ljpf_pkg::DIAM_W-1:0]       target_diameter;
    logic [ljpf_pkg::DIAM_W-1:0]       neighbour_diameter;
    logic                              skip_pair;
    logic                              last_pair;

    modport source (
        output valid, target_x, target_y, target_z, neighbour_x, neighbour_y, neighbour_z,
        output target_diameter, neighbour_diameter, skip_pair, last_pair,
        input  ready
    );
    modport sink (
        input  valid, target_x, target_y, target_z, neighbour_x, neighbour_y, neighbour_z,
        input  target_diameter, neighbour_diameter, skip_pair, last_pair,
        output ready
    );
endinterface

interface ljpf_force_if;
    logic                                valid;
    logic                                ready;
    logic signed [ljpf_pkg::FORCE_W-1:0] force_x;
    logic signed [ljpf_pkg::FORCE_W-1:0] force_y;
    logic signed [ljpf_pkg::FORCE_W-1:0] force_z;

    modport source (output valid, force_x, force_y, force_z, input ready);
    modport sink (input valid, force_x, force_y, force_z, output ready);
endinterface

interface ljpf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ljpf_pkg::CFG_IDX_W-1:0]     index;
    logic [ljpf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/repulsive_lj_pair_force_accumulator.sv =====
// channel      | dir | handshake   | word
// pair_in      | in  | valid/ready | target and neighbour positions, diameters, skip, last
// force_out    | out | valid/ready | saturated force sum x, y, z (Q24.24)
// cfg          | in  | valid/ready | register index and write data, always ready
//
// the front registers each pair; the back pops one skipped or far pair per cycle, but a
// last pair also passes the emit state, which waits for a free output register; a pair
// outside the cutoff takes five multiplies on the shared multiply/divide unit, one inside
// it adds a division, three multiplies and a multiply and division per nonzero term
// the result word sits in an output register, so the back keeps working while one waits
// reset clears the sums, the queue, the sequencer and loads the register defaults
//
// top level of the repulsive pair force accumulator; depends on ljpf_pkg, ljpf_if,
// ljpf_front, ljpf_fifo, ljpf_muldiv, ljpf_back

module repulsive_lj_pair_force_accumulator #(
    parameter int POSITION_WIDTH = ljpf_pkg::POSITION_WIDTH_DEF,
    parameter int FRACTION_BITS  = ljpf_pkg::FRACTION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ljpf_pair_if.sink      pair_in,
    ljpf_force_if.source   force_out,
    ljpf_cfg_if.sink       cfg
);
    import ljpf_pkg::*;

    logic [BOX_W-1:0] box_x_reg, box_y_reg;
    logic [CUT_W-1:0] cutoff_reg;

    logic    push_valid, push_ready, pop_valid, pop_ready;
    pair_t   push_data, pop_data;
    md_req_t md_req;
    md_rsp_t md_rsp;
    logic [MD_P_W-1:0] md_opa, md_result;
    logic [MD_A_W-1:0] md_opb, md_limit;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg  <= BOX_W'(655360);
            box_y_reg  <= BOX_W'(655360);
            cutoff_reg <= CUT_W'(82570);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_BOX_X:  box_x_reg  <= cfg.data[BOX_W-1:0];
                REG_BOX_Y:  box_y_reg  <= cfg.data[BOX_W-1:0];
                REG_CUTOFF: cutoff_reg <= cfg.data[CUT_W-1:0];
                default:    cutoff_reg <= cutoff_reg;
            endcase
        end
    end

    ljpf_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_in    (pair_in),
        .box_x      (box_x_reg),
        .box_y      (box_y_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ljpf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ljpf_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .opa    (md_opa),
        .opb    (md_opb),
        .limit  (md_limit),
        .rsp    (md_rsp),
        .result (md_result)
    );

    ljpf_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .cutoff    (cutoff_reg),
        .md_req    (md_req),
        .md_opa    (md_opa),
        .md_opb    (md_opb),
        .md_limit  (md_limit),
        .md_rsp    (md_rsp),
        .md_result (md_result),
        .force_out (force_out)
    );

endmodule

// ===== rtl/ljpf_front.sv =====
// ljpf_front: takes pair words, forms separations with minimum image in x and y,
// classifies near/far/skip; depends on ljpf_pkg and ljpf_if

module ljpf_front #(
    parameter int POSITION_WIDTH = ljpf_pkg::POSITION_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ljpf_pair_if.sink                   pair_in,
    input  logic [ljpf_pkg::BOX_W-1:0]  box_x,
    input  logic [ljpf_pkg::BOX_W-1:0]  box_y,
    output logic                        push_valid,
    input  logic                        push_ready,
    output ljpf_pkg::pair_t             push_data
);
    import ljpf_pkg::*;

    localparam int DIFF_W = POSITION_WIDTH + 1;
    localparam int WRAP_W = ((DIFF_W > BOX_W + 1) ? DIFF_W : BOX_W + 1) + 2;
    localparam logic signed [WRAP_W-1:0] SEP_HI = WRAP_W'(1) << SEP_BITS;
    localparam logic signed [WRAP_W-1:0] SEP_LO = -SEP_HI;

    logic                     valid_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [DSUM_W-1:0]        dsum_reg;
    logic                     skip_reg, last_reg;

    logic signed [WRAP_W-1:0] wx, wy, wz;
    logic                     near;

    // nearest periodic image of one component
    function automatic logic signed [WRAP_W-1:0] wrap_comp(
        input logic signed [WRAP_W-1:0] v,
        input logic signed [WRAP_W-1:0] len
    );
        logic signed [WRAP_W-1:0] twice;
        twice = v + v;
        if (twice > len)
            return v - len;
        else if (twice < -len)
            return v + len;
        else
            return v;
    endfunction

    assign pair_in.ready = !valid_reg || push_ready;

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pair_in.ready)
            valid_reg <= pair_in.valid;
    end

    // raw separation and diameter sum
    always_ff @(posedge clk)
    begin
        if (pair_in.valid && pair_in.ready)
        begin
            dx_reg   <= DIFF_W'(pair_in.target_x) - DIFF_W'(pair_in.neighbour_x);
            dy_reg   <= DIFF_W'(pair_in.target_y) - DIFF_W'(pair_in.neighbour_y);
            dz_reg   <= DIFF_W'(pair_in.target_z) - DIFF_W'(pair_in.neighbour_z);
            dsum_reg <= DSUM_W'(pair_in.target_diameter) + DSUM_W'(pair_in.neighbour_diameter);
            skip_reg <= pair_in.skip_pair;
            last_reg <= pair_in.last_pair;
        end
    end

    // wrap and far test
    always_comb
    begin
        wx = wrap_comp(WRAP_W'(dx_reg), $signed({{(WRAP_W-BOX_W){1'b0}}, box_x}));
        wy = wrap_comp(WRAP_W'(dy_reg), $signed({{(WRAP_W-BOX_W){1'b0}}, box_y}));
        wz = WRAP_W'(dz_reg);
        near = (wx < SEP_HI) && (wx > SEP_LO) && (wy < SEP_HI) && (wy > SEP_LO)
            && (wz < SEP_HI) && (wz > SEP_LO);
        push_data.dx     = wx[COMP_W-1:0];
        push_data.dy     = wy[COMP_W-1:0];
        push_data.dz     = wz[COMP_W-1:0];
        push_data.dsum   = dsum_reg;
        push_data.active = near && !skip_reg;
        push_data.last   = last_reg;
    end

    assign push_valid = valid_reg;

endmodule

// ===== rtl/ljpf_fifo.sv =====
// ljpf_fifo: short queue of classified pairs between front and back
// depends on ljpf_pkg

module ljpf_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ljpf_pkg::pair_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ljpf_pkg::pair_t  pop_data
);
    import ljpf_pkg::*;

    pair_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/ljpf_muldiv.sv =====
// ljpf_muldiv: shared multi-cycle unit, 64x64 multiply by 16-bit digits and
// saturating restoring division of a 128-bit word; depends on ljpf_pkg

module ljpf_muldiv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ljpf_pkg::md_req_t            req,
    input  logic [ljpf_pkg::MD_P_W-1:0]  opa,
    input  logic [ljpf_pkg::MD_A_W-1:0]  opb,
    input  logic [ljpf_pkg::MD_A_W-1:0]  limit,
    output ljpf_pkg::md_rsp_t            rsp,
    output logic [ljpf_pkg::MD_P_W-1:0]  result
);
    import ljpf_pkg::*;

    localparam int PART_W = MD_A_W + MD_DIGIT;

    logic                 busy_reg, div_reg, done_reg;
    logic [MD_CNT_W-1:0]  cnt_reg;
    logic [MD_P_W-1:0]    acc_reg;
    logic [MD_A_W-1:0]    a_reg, b_reg, rem_reg, q_reg, limit_reg;
    logic                 ovf_reg;

    logic [PART_W-1:0]    part;
    logic [MD_P_W-1:0]    mul_next;
    logic [MD_A_W:0]      cand;
    logic                 ge;
    logic [MD_A_W-1:0]    rem_new, q_new, q_sat;
    logic                 ovf_new;

    // one multiply digit or one quotient bit
    always_comb
    begin
        part     = a_reg * b_reg[MD_A_W-1 -: MD_DIGIT];
        mul_next = (acc_reg << MD_DIGIT) + MD_P_W'(part);
        cand     = {rem_reg, acc_reg[MD_P_W-1]};
        ge       = cand >= {1'b0, b_reg};
        rem_new  = ge ? MD_A_W'(cand - {1'b0, b_reg}) : cand[MD_A_W-1:0];
        q_new    = {q_reg[MD_A_W-2:0], ge};
        ovf_new  = ovf_reg | q_reg[MD_A_W-1];
        q_sat    = (ovf_new || ((q_new & ~limit_reg) != '0)) ? limit_reg : q_new;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.is_div ? MD_CNT_W'(MD_DIV_STEPS) : MD_CNT_W'(MD_MUL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MD_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            div_reg   <= req.is_div;
            acc_reg   <= req.is_div ? opa : '0;
            a_reg     <= opa[MD_A_W-1:0];
            b_reg     <= opb;
            rem_reg   <= '0;
            q_reg     <= '0;
            ovf_reg   <= 1'b0;
            limit_reg <= limit;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg <= rem_new;
                q_reg   <= q_new;
                ovf_reg <= ovf_new;
                if (cnt_reg == MD_CNT_W'(1))
                    acc_reg <= MD_P_W'(q_sat);
                else
                    acc_reg <= acc_reg << 1;
            end
            else
            begin
                acc_reg <= mul_next;
                b_reg   <= b_reg << MD_DIGIT;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

// ===== rtl/ljpf_back.sv =====
// ljpf_back: sequencer that works one queued pair through the shared unit,
// accumulates saturated force sums and holds the result word; depends on ljpf_pkg, ljpf_if

module ljpf_back #(
    parameter int FRACTION_BITS = ljpf_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  ljpf_pkg::pair_t              pop_data,
    input  logic [ljpf_pkg::CUT_W-1:0]   cutoff,
    output ljpf_pkg::md_req_t            md_req,
    output logic [ljpf_pkg::MD_P_W-1:0]  md_opa,
    output logic [ljpf_pkg::MD_A_W-1:0]  md_opb,
    output logic [ljpf_pkg::MD_A_W-1:0]  md_limit,
    input  ljpf_pkg::md_rsp_t            md_rsp,
    input  logic [ljpf_pkg::MD_P_W-1:0]  md_result,
    ljpf_force_if.source                 force_out
);
    import ljpf_pkg::*;

    localparam int TERM_SHIFT = FRACTION_BITS + 8;
    localparam int THR_W      = 2 * MD_A_W - THR_SHIFT;

    back_state_e state_reg, state_next;
    pair_t       item_reg;
    logic [1:0]  comp_reg;
    logic        issued_reg;
    logic [R2_W-1:0]   r2_reg;
    logic [DSQ_W-1:0]  dsq_reg;
    logic [S_W-1:0]    s_reg;
    logic [T_W-1:0]    t_reg;
    logic [U_W-1:0]    u_reg;
    logic [X_W-1:0]    x_reg;
    logic [VMAG_W-1:0] vmag_reg;
    logic              vneg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic signed [FORCE_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [FORCE_W-1:0] fx_reg, fy_reg, fz_reg;
    logic              out_valid_reg;

    logic signed [COMP_W-1:0] comp_val;
    logic [MAG_W-1:0]  cm;
    logic              vec_skip, need_unit, out_free, last_comp, out_of_range;
    logic [THR_W:0]    thr_sum;
    logic [THR_W-THR_SHIFT:0] thr;
    logic [X_W-1:0]    h_val, vdiff;
    logic              term_neg;
    back_state_e       fin_state;

    // saturating add of a signed magnitude term
    function automatic logic signed [FORCE_W-1:0] sat_add(
        input logic signed [FORCE_W-1:0] acc,
        input logic [Q_W-1:0]            q,
        input logic                      neg
    );
        logic signed [FORCE_W:0] s;
        s = neg ? ((FORCE_W+1)'(acc) - $signed((FORCE_W+1)'(q)))
                : ((FORCE_W+1)'(acc) + $signed((FORCE_W+1)'(q)));
        if (s[FORCE_W] != s[FORCE_W-1])
            return s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
        else
            return s[FORCE_W-1:0];
    endfunction

    // selected component, cutoff threshold, potential factor
    always_comb
    begin
        case (comp_reg)
            2'd0:    comp_val = item_reg.dx;
            2'd1:    comp_val = item_reg.dy;
            2'd2:    comp_val = item_reg.dz;
            default: comp_val = '0;
        endcase
        cm           = comp_val[COMP_W-1] ? MAG_W'(-comp_val) : comp_val[MAG_W-1:0];
        last_comp    = (comp_reg == 2'd2);
        vec_skip     = (cm == '0) || (vmag_reg == '0);
        out_free     = !out_valid_reg || force_out.ready;
        thr_sum      = (THR_W+1)'(md_result[2*MD_A_W-1-THR_SHIFT+THR_SHIFT-1:0])
                     + (THR_W+1)'(THR_ROUND);
        thr          = thr_sum[THR_W:THR_SHIFT];
        out_of_range = ((THR_W+1)'(r2_reg) >= (THR_W+1)'(thr)) || (r2_reg == '0);
        h_val        = X_W'(u_reg[U_W-1:U_W-H_W]);
        vdiff        = (x_reg < h_val) ? (h_val - x_reg) : (x_reg - h_val);
        term_neg     = vneg_reg ^ comp_val[COMP_W-1];
        fin_state    = item_reg.last ? ST_EMIT : ST_IDLE;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (pop_valid)
                begin
                    if (pop_data.active)
                        state_next = ST_R2;
                    else if (pop_data.last)
                        state_next = ST_EMIT;
                end
            ST_R2:
                if (md_rsp.done && last_comp)
                    state_next = ST_DSQ;
            ST_DSQ:
                if (md_rsp.done)
                    state_next = ST_THR;
            ST_THR:
                if (md_rsp.done)
                    state_next = out_of_range ? fin_state : ST_S;
            ST_S:
                if (md_rsp.done)
                    state_next = ST_T;
            ST_T:
                if (md_rsp.done)
                    state_next = ST_U;
            ST_U:
                if (md_rsp.done)
                    state_next = ST_X;
            ST_X:
                if (md_rsp.done)
                    state_next = ST_V;
            ST_V:
                state_next = ST_VM;
            ST_VM:
                if (vec_skip)
                    state_next = last_comp ? fin_state : ST_VM;
                else if (md_rsp.done)
                    state_next = ST_VD;
            ST_VD:
                if (md_rsp.done)
                    state_next = last_comp ? fin_state : ST_VM;
            ST_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // unit requests and operands
    always_comb
    begin
        need_unit = 1'b0;
        md_opa    = '0;
        md_opb    = '0;
        md_limit  = '0;
        md_req.is_div = 1'b0;
        case (state_reg)
            ST_R2:
            begin
                need_unit = 1'b1;
                md_opa    = MD_P_W'(cm);
                md_opb    = MD_A_W'(cm);
            end
            ST_DSQ:
            begin
                need_unit = 1'b1;
                md_opa    = MD_P_W'(item_reg.dsum);
                md_opb    = MD_A_W'(item_reg.dsum);
            end
            ST_THR:
            begin
                need_unit = 1'b1;
                md_opa    = MD_P_W'(cutoff);
                md_opb    = MD_A_W'(dsq_reg);
            end
            ST_S:
            begin
                need_unit     = 1'b1;
                md_req.is_div = 1'b1;
                md_opa        = MD_P_W'(dsq_reg) << S_SHIFT;
                md_opb        = MD_A_W'(r2_reg);
                md_limit      = S_CAP;
            end
            ST_T:
            begin
                need_unit = 1'b1;
                md_opa    = MD_P_W'(s_reg);
                md_opb    = MD_A_W'(s_reg);
            end
            ST_U:
            begin
                need_unit = 1'b1;
                md_opa    = MD_P_W'(t_reg);
                md_opb    = MD_A_W'(s_reg);
            end
            ST_X:
            begin
                need_unit = 1'b1;
                md_opa    = MD_P_W'(u_reg);
                md_opb    = MD_A_W'(u_reg);
            end
            ST_VM:
            begin
                need_unit = !vec_skip;
                md_opa    = MD_P_W'(vmag_reg);
                md_opb    = MD_A_W'(cm);
            end
            ST_VD:
            begin
                need_unit     = 1'b1;
                md_req.is_div = 1'b1;
                md_opa        = MD_P_W'(prod_reg) << TERM_SHIFT;
                md_opb        = MD_A_W'(r2_reg);
                md_limit      = TERM_CAP;
            end
            default:
                need_unit = 1'b0;
        endcase
        md_req.start = need_unit && !issued_reg;
        pop_ready    = (state_reg == ST_IDLE);
    end

    // control, sums and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (md_rsp.done)
                issued_reg <= 1'b0;
            else if (md_req.start)
                issued_reg <= 1'b1;
            if (state_reg == ST_VD && md_rsp.done)
            begin
                case (comp_reg)
                    2'd0:    sum_x_reg <= sat_add(sum_x_reg, md_result[Q_W-1:0], term_neg);
                    2'd1:    sum_y_reg <= sat_add(sum_y_reg, md_result[Q_W-1:0], term_neg);
                    default: sum_z_reg <= sat_add(sum_z_reg, md_result[Q_W-1:0], term_neg);
                endcase
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
                sum_z_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (force_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // pair payload and intermediate values
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (pop_valid)
                begin
                    item_reg <= pop_data;
                    comp_reg <= 2'd0;
                    r2_reg   <= '0;
                end
            ST_R2:
                if (md_rsp.done)
                begin
                    r2_reg   <= r2_reg + R2_W'(md_result[2*MAG_W-1:0]);
                    comp_reg <= last_comp ? 2'd0 : comp_reg + 2'd1;
                end
            ST_DSQ:
                if (md_rsp.done)
                    dsq_reg <= md_result[DSQ_W-1:0];
            ST_S:
                if (md_rsp.done)
                    s_reg <= md_result[S_W-1:0];
            ST_T:
                if (md_rsp.done)
                    t_reg <= md_result[T_W+31:32];
            ST_U:
                if (md_rsp.done)
                    u_reg <= md_result[U_W+31:32];
            ST_X:
                if (md_rsp.done)
                    x_reg <= md_result[X_W+47:48];
            ST_V:
            begin
                vneg_reg <= (x_reg < h_val);
                vmag_reg <= (VMAG_W'(vdiff) << 5) + (VMAG_W'(vdiff) << 4);
                comp_reg <= 2'd0;
            end
            ST_VM:
                if (vec_skip)
                    comp_reg <= comp_reg + 2'd1;
                else if (md_rsp.done)
                    prod_reg <= md_result[PROD_W-1:0];
            ST_VD:
                if (md_rsp.done)
                    comp_reg <= comp_reg + 2'd1;
            ST_EMIT:
                if (out_free)
                begin
                    fx_reg <= sum_x_reg;
                    fy_reg <= sum_y_reg;
                    fz_reg <= sum_z_reg;
                end
            default:
                comp_reg <= comp_reg;
        endcase
    end

    assign force_out.valid   = out_valid_reg;
    assign force_out.force_x = fx_reg;
    assign force_out.force_y = fy_reg;
    assign force_out.force_z = fz_reg;

`ifndef NO_ASSERTIONS
    // a request only goes to an idle unit
    assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("unit started while busy");

    // the unit only answers a state that asked for it
    assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg != ST_IDLE && state_reg != ST_EMIT && state_reg != ST_V))
        else $error("unit answer in a state without request");

    // emitting a result clears the running sums and raises valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=>
        (sum_x_reg == '0 && sum_y_reg == '0 && sum_z_reg == '0 && out_valid_reg))
        else $error("sums not cleared on emit");
`endif

endmodule

// ===== tb/repulsive_lj_pair_force_accumulator_tb.sv =====
// testbench of the repulsive pair force accumulator: directed and random pair runs
// checked word by word against an in-bench force predictor; depends on ljpf_pkg, ljpf_if
// and the repulsive_lj_pair_force_accumulator top level
`timescale 1ns / 100ps

module repulsive_lj_pair_force_accumulator_tb;

    import ljpf_pkg::*;

    localparam int       PW         = 32;
    localparam longint   SEP_MAX    = 64'sd1 <<< 26;
    localparam longint   SUM_HI     = (64'sd1 <<< 47) - 1;
    localparam longint   SUM_LO     = -(64'sd1 <<< 47);
    localparam int       DRAIN_WAIT = 1000;

    typedef struct {
        logic signed [PW-1:0] tx, ty, tz, nx, ny, nz;
        logic [DIAM_W-1:0]    td, nd;
        logic                 skip, last;
    } pair_word_t;

    typedef struct {
        logic signed [FORCE_W-1:0] fx, fy, fz;
    } force_word_t;

    logic clk;
    logic rst_n;

    ljpf_pair_if #(.POSITION_WIDTH(PW)) pair_bus ();
    ljpf_force_if                       force_bus ();
    ljpf_cfg_if                         cfg_bus ();

    repulsive_lj_pair_force_accumulator #(
        .POSITION_WIDTH(PW),
        .FRACTION_BITS (16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair_in  (pair_bus),
        .force_out(force_bus),
        .cfg      (cfg_bus)
    );

    // predictor state and configuration copy
    longint      box_x_m, box_y_m, cutoff_m;
    longint      acc_x, acc_y, acc_z;
    force_word_t pending_forces[$];
    bit          failed;
    bit          tx_quiet, rx_quiet, rx_hold;

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // timeout
    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint wrap_image(longint v, longint len);
        if (2 * v > len) v = v - len;
        if (2 * v < -len) v = v + len;
        return v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) s = SUM_HI;
        if (s < SUM_LO) s = SUM_LO;
        return s;
    endfunction

    // one component of the pair force, truncated toward zero and capped
    function automatic longint force_term(logic [63:0] vmag, bit vneg, longint c,
                                          logic [63:0] r2);
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  cm;
        cm = (c < 0) ? -c : c;
        if (cm == 0 || vmag == 0) return 0;
        num = (128'(vmag) * 128'(cm)) << 24;
        q = num / 128'(r2);
        if (q > 128'(TERM_CAP)) q = 128'(TERM_CAP);
        return (vneg != (c < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // repulsive force of one pair added into the running sums
    function automatic void add_pair_force(longint dx, longint dy, longint dz,
                                           logic [63:0] dsum);
        logic [63:0]  ax, ay, az, r2, dsq, thr, s, t, u, x, h, vmag;
        logic [127:0] w;
        bit           vneg;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        if (ax >= SEP_MAX || ay >= SEP_MAX || az >= SEP_MAX) return;
        r2 = ax * ax + ay * ay + az * az;
        dsq = dsum * dsum;
        w = 128'(cutoff_m) * 128'(dsq) + 128'(THR_ROUND);
        w = w >> THR_SHIFT;
        thr = w[63:0];
        if (r2 >= thr || r2 == 0) return;
        w = (128'(dsq) << S_SHIFT) / 128'(r2);
        s = (w > 128'(S_CAP)) ? S_CAP : w[63:0];
        w = (128'(s) * 128'(s)) >> 32;
        t = w[63:0];
        w = (128'(t) * 128'(s)) >> 32;
        u = w[63:0];
        w = (128'(u) * 128'(u)) >> 48;
        x = w[63:0];
        h = u >> 17;
        vneg = (x < h);
        vmag = 48 * (vneg ? h - x : x - h);
        acc_x = sat_add(acc_x, force_term(vmag, vneg, dx, r2));
        acc_y = sat_add(acc_y, force_term(vmag, vneg, dy, r2));
        acc_z = sat_add(acc_z, force_term(vmag, vneg, dz, r2));
    endfunction

    // advance the predictor by one accepted pair word
    function automatic void predict_pair(pair_word_t p);
        longint      dx, dy, dz;
        force_word_t f;
        dx = wrap_image(longint'(p.tx) - longint'(p.nx), box_x_m);
        dy = wrap_image(longint'(p.ty) - longint'(p.ny), box_y_m);
        dz = longint'(p.tz) - longint'(p.nz);
        if (!p.skip) add_pair_force(dx, dy, dz, 64'(p.td) + 64'(p.nd));
        if (p.last)
        begin
            f.fx = acc_x[FORCE_W-1:0];
            f.fy = acc_y[FORCE_W-1:0];
            f.fz = acc_z[FORCE_W-1:0];
            pending_forces.push_back(f);
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
        end
    endfunction

    function automatic pair_word_t mk_pair(longint tx, longint ty, longint tz, longint nx,
                                           longint ny, longint nz, int td, int nd,
                                           bit skip, bit last);
        pair_word_t p;
        p.tx = tx[PW-1:0];
        p.ty = ty[PW-1:0];
        p.tz = tz[PW-1:0];
        p.nx = nx[PW-1:0];
        p.ny = ny[PW-1:0];
        p.nz = nz[PW-1:0];
        p.td = td[DIAM_W-1:0];
        p.nd = nd[DIAM_W-1:0];
        p.skip = skip;
        p.last = last;
        return p;
    endfunction

    // random pair: mostly near contact, sometimes across the box, some noise
    function automatic pair_word_t rand_pair(bit last);
        pair_word_t p;
        longint     d, off[3];
        int         sel;
        sel = $urandom_range(0, 99);
        p.tx = $urandom;
        p.ty = $urandom;
        p.tz = $urandom;
        p.skip = ($urandom_range(0, 9) == 0);
        p.last = last;
        if (sel < 12)
        begin
            p.nx = $urandom;
            p.ny = $urandom;
            p.nz = $urandom;
            p.td = $urandom;
            p.nd = $urandom;
        end
        else
        begin
            if (sel < 20)
            begin
                p.td = $urandom_range(0, 16777215);
                p.nd = $urandom_range(0, 16777215);
            end
            else
            begin
                p.td = $urandom_range(20000, 140000);
                p.nd = $urandom_range(20000, 140000);
            end
            d = (longint'(p.td) + longint'(p.nd)) / 2;
            for (int k = 0; k < 3; k++)
            begin
                off[k] = $urandom_range(0, int'(d * 5 / 4));
                if ($urandom_range(0, 1)) off[k] = -off[k];
            end
            if ($urandom_range(0, 3) == 0) off[0] = off[0] + box_x_m;
            if ($urandom_range(0, 3) == 0) off[1] = off[1] - box_y_m;
            p.nx = p.tx - off[0][PW-1:0];
            p.ny = p.ty - off[1][PW-1:0];
            p.nz = p.tz - off[2][PW-1:0];
        end
        return p;
    endfunction

    // send one pair word; valid stays high after acceptance
    task automatic send_pair(pair_word_t p);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            pair_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_bus.valid              <= 1'b1;
        pair_bus.target_x           <= p.tx;
        pair_bus.target_y           <= p.ty;
        pair_bus.target_z           <= p.tz;
        pair_bus.neighbour_x        <= p.nx;
        pair_bus.neighbour_y        <= p.ny;
        pair_bus.neighbour_z        <= p.nz;
        pair_bus.target_diameter    <= p.td;
        pair_bus.neighbour_diameter <= p.nd;
        pair_bus.skip_pair          <= p.skip;
        pair_bus.last_pair          <= p.last;
        @(posedge clk);
        while (!pair_bus.ready) @(posedge clk);
        predict_pair(p);
    endtask

    // wait for every expected force word, then let the back settle
    task automatic drain_forces();
        pair_bus.valid <= 1'b0;
        while (pending_forces.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        case (idx)
            REG_BOX_X:  box_x_m  = longint'(data[BOX_W-1:0]);
            REG_BOX_Y:  box_y_m  = longint'(data[BOX_W-1:0]);
            REG_CUTOFF: cutoff_m = longint'(data[CUT_W-1:0]);
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_runs(int count);
        int n, len;
        n = 0;
        while (n < count)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) send_pair(rand_pair(k == len - 1));
            n += len;
        end
    endtask

    task automatic test_directed();
        // coincident particles inside the cutoff
        send_pair(mk_pair(100, 200, 300, 100, 200, 300, 65536, 65536, 0, 1));
        // zero diameters
        send_pair(mk_pair(0, 0, 0, 30000, 0, 0, 0, 0, 0, 1));
        // far pair at the position extremes
        send_pair(mk_pair(2147483647, -2147483648, 2147483647,
                          -2147483648, 2147483647, -2147483648, 65536, 65536, 0, 1));
        // very close pairs with largest diameters drive the sum to saturation
        send_pair(mk_pair(1, 0, 0, 0, 0, 0, 16777215, 16777215, 0, 0));
        send_pair(mk_pair(0, 1, 0, 0, 0, 0, 16777215, 16777215, 0, 0));
        send_pair(mk_pair(0, 0, 5, 0, 0, 6, 16777215, 16777215, 0, 1));
        send_pair(mk_pair(-1, -1, 0, 0, 0, 0, 16777215, 16777215, 0, 0));
        send_pair(mk_pair(-1, -1, 0, 0, 0, 0, 16777215, 16777215, 0, 1));
        // contributing pair then a skipped last pair
        send_pair(mk_pair(0, 0, 0, 60000, 0, 0, 65536, 65536, 0, 0));
        send_pair(mk_pair(0, 0, 0, 1000, 0, 0, 65536, 65536, 1, 1));
        // near contact along each axis
        send_pair(mk_pair(65536, 0, 0, 0, 0, 0, 65536, 65536, 0, 0));
        send_pair(mk_pair(0, -70000, 0, 0, 0, 0, 65536, 65536, 0, 0));
        send_pair(mk_pair(0, 0, 50000, 0, 0, 0, 65536, 65536, 0, 1));
        // minimum image wrap across the box in x and y
        send_pair(mk_pair(327000, 0, 0, -327000, 0, 0, 65536, 65536, 0, 0));
        send_pair(mk_pair(0, -327000, 0, 0, 327000, 0, 65536, 65536, 0, 1));
        // attractive side of the curve near cutoff
        send_pair(mk_pair(0, 0, 0, 72000, 10000, -5000, 65536, 65000, 0, 1));
        // all-ones and all-zeros patterns, the first pair skipped
        send_pair(mk_pair(-1, -1, -1, 0, 0, 0, 16777215, 0, 1, 0));
        send_pair(mk_pair(0, 0, 0, -1, -1, -1, 0, 16777215, 0, 1));
        drain_forces();
    endtask

    task automatic test_config_phases();
        // box and cutoff settings, extremes included
        logic [CFG_DATA_W-1:0] bx[5], by[5], cf[5];
        bx = '{32'd655360, 32'd196608, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
        by = '{32'd655360, 32'd131072, 32'h7FFF_FFFF, 32'd0, 32'h8001_0000};
        cf = '{32'd82570, 32'hF_FFFF, 32'd0, 32'd82570, 32'hFFF1_4000};
        for (int ph = 0; ph < 5; ph++)
        begin
            cfg_write(REG_BOX_X, bx[ph]);
            cfg_write(REG_BOX_Y, by[ph]);
            cfg_write(REG_CUTOFF, cf[ph]);
            tx_quiet = (ph == 1);
            rx_quiet = (ph == 1 || ph == 3);
            send_runs(260);
            drain_forces();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        cfg_write(REG_BOX_X, 32'd655360);
        cfg_write(REG_BOX_Y, 32'd655360);
        cfg_write(REG_CUTOFF, 32'd82570);
    endtask

    task automatic test_backpressure();
        // receiver holds off while last pairs pile up
        tx_quiet = 1'b1;
        fork
            begin
                rx_hold = 1'b1;
                repeat (4000) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none
        for (int k = 0; k < 40; k++) send_pair(rand_pair(1'b1));
        tx_quiet = 1'b0;
        // sender pauses until everything has come back
        drain_forces();
        send_runs(40);
        drain_forces();
    endtask

    // receiver: random stalls, quiet stretches and the long hold
    initial
    begin
        int gap;
        force_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = rx_quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0 || rx_hold)
            begin
                force_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            force_bus.ready <= 1'b1;
            @(posedge clk);
            while (!force_bus.valid && !rx_hold) @(posedge clk);
        end
    end

    // compare each accepted force word with the oldest prediction
    always @(posedge clk)
    begin
        force_word_t e;
        if (rst_n && force_bus.valid && force_bus.ready)
        begin
            if (pending_forces.size() == 0)
            begin
                $display("%t unexpected force word x=%h y=%h z=%h", $realtime,
                         force_bus.force_x, force_bus.force_y, force_bus.force_z);
                failed = 1'b1;
            end
            else
            begin
                e = pending_forces.pop_front();
                if (force_bus.force_x !== e.fx)
                begin
                    $display("%t force_x expected %h actual %h", $realtime, e.fx,
                             force_bus.force_x);
                    failed = 1'b1;
                end
                if (force_bus.force_y !== e.fy)
                begin
                    $display("%t force_y expected %h actual %h", $realtime, e.fy,
                             force_bus.force_y);
                    failed = 1'b1;
                end
                if (force_bus.force_z !== e.fz)
                begin
                    $display("%t force_z expected %h actual %h", $realtime, e.fz,
                             force_bus.force_z);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        failed   = 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        rx_hold  = 1'b0;
        box_x_m  = 655360;
        box_y_m  = 655360;
        cutoff_m = 82570;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        rst_n = 1'b0;
        pair_bus.valid = 1'b0;
        pair_bus.target_x = '0;
        pair_bus.target_y = '0;
        pair_bus.target_z = '0;
        pair_bus.neighbour_x = '0;
        pair_bus.neighbour_y = '0;
        pair_bus.neighbour_z = '0;
        pair_bus.target_diameter = '0;
        pair_bus.neighbour_diameter = '0;
        pair_bus.skip_pair = 1'b0;
        pair_bus.last_pair = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_BOX_X;
        cfg_bus.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_phases();
        test_backpressure();

        if (!failed && pending_forces.size() == 0)
            $display("All tests passed");
        else
        begin
            if (pending_forces.size() != 0)
                $display("%t %0d force words never arrived", $realtime,
                         pending_forces.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
